/* hdl/lkrc_pkg.sv */
// Package for the keyed result cache: command codes, key, scan token and
// write-back bundles shared by the cell row and the top level.
// No dependencies.
package lkrc_pkg;

    localparam int KEY_MONTH_W = 4;
    localparam int KEY_YEAR_W  = 14;
    localparam int START_W     = 64;
    localparam int LEN_W       = 5;
    localparam int STAMP_W     = 32;
    localparam int SLOT_W      = 5;

    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_SETLEN = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [KEY_MONTH_W-1:0] month;
        logic [KEY_YEAR_W-1:0]  year;
        logic                   leap;
        logic                   scheme;
    } t_key;

    // Running scan result handed from cell to cell.
    typedef struct packed {
        logic               valid;
        logic               hit;
        logic               empty;
        logic               have_min;
        logic [STAMP_W-1:0] min_stamp;
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   len;
    } t_tok;

    // Write-back broadcast to the row.
    typedef struct packed {
        logic               key_we;
        logic               start_we;
        logic               len_we;
        logic               stamp_we;
        t_key               key;
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   len;
        logic [STAMP_W-1:0] stamp;
    } t_wr;

endpackage

/* hdl/lkrc_cell.sv */
// One cache entry of the keyed result cache plus its stage of the scan chain.
// Depends on lkrc_pkg.
module lkrc_cell #(
    parameter int ENTRIES = 32,
    parameter int INDEX   = 0
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  lkrc_pkg::t_key                         i_key,
    input  lkrc_pkg::t_tok                         i_tok,
    input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] i_hit_idx,
    input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] i_empty_idx,
    input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] i_min_idx,
    output lkrc_pkg::t_tok                         o_tok,
    output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] o_hit_idx,
    output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] o_empty_idx,
    output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] o_min_idx,
    input  lkrc_pkg::t_wr                          i_wr,
    input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] i_wr_idx
);
    import lkrc_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

    t_key               r_key;
    logic [START_W-1:0] r_start;
    logic [LEN_W-1:0]   r_len;
    logic [STAMP_W-1:0] r_stamp;

    t_tok               r_tok, n_tok;
    logic [IW-1:0]      r_hit_idx, n_hit_idx;
    logic [IW-1:0]      r_empty_idx, n_empty_idx;
    logic [IW-1:0]      r_min_idx, n_min_idx;

    logic               occupied;
    logic               sel;

    assign occupied = (r_start != '0);
    assign sel      = (i_wr_idx == MY_IDX);

    always_comb begin
        n_tok       = i_tok;
        n_hit_idx   = i_hit_idx;
        n_empty_idx = i_empty_idx;
        n_min_idx   = i_min_idx;
        if (i_tok.valid) begin
            if (!i_tok.hit && occupied && (r_key == i_key)) begin
                n_tok.hit   = 1'b1;
                n_tok.start = r_start;
                n_tok.len   = r_len;
                n_hit_idx   = MY_IDX;
            end
            if (!i_tok.empty) begin
                if (!occupied) begin
                    n_tok.empty = 1'b1;
                    n_empty_idx = MY_IDX;
                end else if (!i_tok.have_min || (r_stamp < i_tok.min_stamp)) begin
                    n_tok.have_min  = 1'b1;
                    n_tok.min_stamp = r_stamp;
                    n_min_idx       = MY_IDX;
                end
            end
        end
    end

    // advance the token one cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
        r_hit_idx   <= n_hit_idx;
        r_empty_idx <= n_empty_idx;
        r_min_idx   <= n_min_idx;
    end

    // entry storage; only the start word needs a reset (zero marks empty)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
        end else if (sel && i_wr.start_we) begin
            r_start <= i_wr.start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (sel && i_wr.key_we) begin
            r_key <= i_wr.key;
        end
        if (sel && i_wr.len_we) begin
            r_len <= i_wr.len;
        end
        if (sel && i_wr.stamp_we) begin
            r_stamp <= i_wr.stamp;
        end
    end

    assign o_tok       = r_tok;
    assign o_hit_idx   = r_hit_idx;
    assign o_empty_idx = r_empty_idx;
    assign o_min_idx   = r_min_idx;

endmodule

/* hdl/lru_keyed_result_cache_top.sv */
// Top level of the keyed result cache: request register, scan launch, cell row
// and write-back/result logic. Depends on lkrc_pkg and lkrc_cell.
//
// Fully associative LRU cache of ENTRIES entries. A request is taken when
// start is high and busy is low; its single result appears on the o_ ports
// for exactly one cycle with o_strobe high, and the receiver cannot stall it.
// busy falls in the cycle the result shows, so the block takes no new request
// before the last one is done. The scan token walks the row of cells one entry
// per cycle; as it leaves the last cell, the write-back and the result are
// registered together, and the result then shows on the o_ ports.
// Each cell holds one entry; the token gathers the first match, the first
// empty entry and the lowest stamp as it passes. Keys read as undefined until
// an entry has been written, but an entry only matches once it holds a
// non-zero start word, so unwritten keys never show.
module lru_keyed_result_cache_top #(
    parameter int ENTRIES = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [1:0]                            i_command,
    input  logic [lkrc_pkg::KEY_MONTH_W-1:0]      i_month,
    input  logic signed [lkrc_pkg::KEY_YEAR_W-1:0] i_year,
    input  logic                                  i_leap_flag,
    input  logic                                  i_scheme_kind,
    input  logic [lkrc_pkg::START_W-1:0]          i_start_value,
    input  logic [lkrc_pkg::LEN_W-1:0]            i_month_length,
    output logic                                  o_strobe,
    output logic                                  o_hit,
    output logic [lkrc_pkg::START_W-1:0]          o_found_start,
    output logic [lkrc_pkg::LEN_W-1:0]            o_found_length,
    output logic [lkrc_pkg::SLOT_W-1:0]           o_slot
);
    import lkrc_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } t_state;

    t_state             r_state, n_state;
    logic               accept;
    logic               r_launch;

    // request register
    t_cmd               r_cmd;
    t_key               r_key;
    logic [START_W-1:0] r_sv;
    logic [LEN_W-1:0]   r_len;

    logic [STAMP_W-1:0] r_counter;
    logic [STAMP_W-1:0] fresh_stamp;

    // scan chain
    t_tok               tok       [ENTRIES+1];
    logic [IW-1:0]      hit_idx   [ENTRIES+1];
    logic [IW-1:0]      empty_idx [ENTRIES+1];
    logic [IW-1:0]      min_idx   [ENTRIES+1];

    t_tok               tail;
    t_wr                wr;
    logic [IW-1:0]      wr_idx;

    // result
    logic               n_hit;
    logic [START_W-1:0] n_found_start;
    logic [LEN_W-1:0]   n_found_length;
    logic [IW+4:0]      slot_ext;
    logic               r_strobe;
    logic               r_hit;
    logic [START_W-1:0] r_found_start;
    logic [LEN_W-1:0]   r_found_length;
    logic [SLOT_W-1:0]  r_slot;

    assign busy   = (r_state == ST_SCAN);
    assign accept = start && !busy;

    // hold the request for the whole scan
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd        <= t_cmd'(i_command);
            r_key.month  <= i_month;
            r_key.year   <= i_year;
            r_key.leap   <= i_leap_flag;
            r_key.scheme <= i_scheme_kind;
            r_sv         <= i_start_value;
            r_len        <= i_month_length;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // drop back to idle as the token leaves the last cell
                if (tail.valid) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_launch <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_launch <= accept;
        end
    end

    // launch an empty token into the first cell
    always_comb begin
        tok[0]          = '0;
        tok[0].valid    = r_launch;
        hit_idx[0]      = '0;
        empty_idx[0]    = '0;
        min_idx[0]      = '0;
    end

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        lkrc_cell #(
            .ENTRIES (ENTRIES),
            .INDEX   (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_key       (r_key),
            .i_tok       (tok[g]),
            .i_hit_idx   (hit_idx[g]),
            .i_empty_idx (empty_idx[g]),
            .i_min_idx   (min_idx[g]),
            .o_tok       (tok[g+1]),
            .o_hit_idx   (hit_idx[g+1]),
            .o_empty_idx (empty_idx[g+1]),
            .o_min_idx   (min_idx[g+1]),
            .i_wr        (wr),
            .i_wr_idx    (wr_idx)
        );
    end

    assign tail        = tok[ENTRIES];
    assign fresh_stamp = r_counter + 1'b1;

    // Write-back and result, decided when the token leaves the row.
    always_comb begin
        wr             = '0;
        wr.key         = r_key;
        wr.start       = r_sv;
        wr.stamp       = fresh_stamp;
        wr.len         = '0;
        wr_idx         = '0;
        n_hit          = 1'b0;
        n_found_start  = '0;
        n_found_length = '0;
        case (r_cmd) inside
            CMD_LOOKUP, CMD_SETLEN: begin
                if (tail.hit) begin
                    wr_idx         = hit_idx[ENTRIES];
                    wr.stamp_we    = tail.valid;
                    n_hit          = 1'b1;
                    n_found_start  = tail.start;
                    n_found_length = tail.len;
                    if (r_cmd == CMD_SETLEN) begin
                        // new length goes out with the result
                        wr.len_we      = tail.valid;
                        wr.len         = r_len;
                        n_found_length = r_len;
                    end
                end
            end
            CMD_INSERT: begin
                // first empty entry, else the oldest stamp
                wr_idx      = tail.empty ? empty_idx[ENTRIES] : min_idx[ENTRIES];
                wr.key_we   = tail.valid;
                wr.start_we = tail.valid;
                wr.len_we   = tail.valid;
                wr.stamp_we = tail.valid;
            end
            default: begin
            end
        endcase
    end

    assign slot_ext = {5'b0, wr_idx};

    // advance the stamp counter with every fresh stamp
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter <= '0;
        end else if (wr.stamp_we) begin
            r_counter <= fresh_stamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= tail.valid;
        end
        if (tail.valid) begin
            r_hit          <= n_hit;
            r_found_start  <= n_found_start;
            r_found_length <= n_found_length;
            r_slot         <= (wr.stamp_we) ? slot_ext[SLOT_W-1:0] : '0;
        end
    end

    assign o_strobe       = r_strobe;
    assign o_hit          = r_hit;
    assign o_found_start  = r_found_start;
    assign o_found_length = r_found_length;
    assign o_slot         = r_slot;

endmodule
